### hdl/xml_markup_lexer_core_defines.svh
// Assertion macros shared by the lexer RTL.
`ifndef XML_MARKUP_LEXER_CORE_DEFINES_SVH
`define XML_MARKUP_LEXER_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define XML_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define XML_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hdl/xml_lex_pkg.sv
// Types, codes and byte classes for the XML markup lexer.
package xml_lex_pkg;

    localparam int POS_BITS   = 16;
    localparam int STATE_W    = 5;
    localparam int EPOS_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int OUT_DATA_W = 32;

    // lexer states
    localparam logic [STATE_W-1:0] ST_OUT    = 5'd0;
    localparam logic [STATE_W-1:0] ST_LT     = 5'd1;
    localparam logic [STATE_W-1:0] ST_SLASH  = 5'd2;
    localparam logic [STATE_W-1:0] ST_NAME   = 5'd3;
    localparam logic [STATE_W-1:0] ST_ATTRWS = 5'd4;
    localparam logic [STATE_W-1:0] ST_ANAME  = 5'd5;
    localparam logic [STATE_W-1:0] ST_PREEQ  = 5'd6;
    localparam logic [STATE_W-1:0] ST_EQ     = 5'd7;
    localparam logic [STATE_W-1:0] ST_VFIRST = 5'd8;
    localparam logic [STATE_W-1:0] ST_PREQ   = 5'd9;
    localparam logic [STATE_W-1:0] ST_VAL    = 5'd10;
    localparam logic [STATE_W-1:0] ST_AFTV   = 5'd11;
    localparam logic [STATE_W-1:0] ST_AFTVWS = 5'd12;
    localparam logic [STATE_W-1:0] ST_GT     = 5'd13;
    localparam logic [STATE_W-1:0] ST_TEXT   = 5'd14;
    localparam logic [STATE_W-1:0] ST_CMT    = 5'd15;
    localparam logic [STATE_W-1:0] ST_CMT1   = 5'd16;
    localparam logic [STATE_W-1:0] ST_CMT2   = 5'd17;
    localparam logic [STATE_W-1:0] ST_BANG   = 5'd18;
    localparam logic [STATE_W-1:0] ST_BANG1  = 5'd19;

    // input word kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // byte roles
    localparam logic [2:0] ROLE_MARKUP = 3'd0;
    localparam logic [2:0] ROLE_TAG    = 3'd1;
    localparam logic [2:0] ROLE_ANAME  = 3'd2;
    localparam logic [2:0] ROLE_AVAL   = 3'd3;
    localparam logic [2:0] ROLE_TEXT   = 3'd4;
    localparam logic [2:0] ROLE_CMT    = 3'd5;

    // events
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_OPEN  = 3'd1;
    localparam logic [2:0] EV_CLOSE = 3'd2;
    localparam logic [2:0] EV_EMPTY = 3'd3;
    localparam logic [2:0] EV_VALUE = 3'd4;
    localparam logic [2:0] EV_TEXT  = 3'd5;

    // characters
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;

    typedef struct packed {
        logic [2:0]        role;
        logic              start;
        logic [2:0]        ev;
        logic              err;
        logic [EPOS_W-1:0] epos;
        logic              ok;
    } t_result;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

endpackage

### hdl/xml_lex_step.sv
// Lexer state registers and the one-word transition and result logic.
module xml_lex_step (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_cmd,
    input  logic [xml_lex_pkg::CHAR_W-1:0]   i_char,
    output xml_lex_pkg::t_result             o_res
);

    logic [xml_lex_pkg::STATE_W-1:0]  r_state, n_state;
    logic                             r_closing, n_closing;
    logic [xml_lex_pkg::POS_BITS-1:0] r_pos, n_pos;
    logic [xml_lex_pkg::POS_BITS-1:0] r_bang, n_bang;
    logic                             r_text, n_text;
    logic                             r_failed, n_failed;

    logic                             bad;
    logic                             blank;
    logic                             letter;
    logic [xml_lex_pkg::POS_BITS-1:0] errp;
    logic [2:0]                       tagdone;

    assign blank   = xml_lex_pkg::is_blank(i_char);
    assign letter  = xml_lex_pkg::is_letter(i_char);
    assign tagdone = r_closing ? xml_lex_pkg::EV_CLOSE : xml_lex_pkg::EV_OPEN;

    always_comb begin
        o_res.role  = xml_lex_pkg::ROLE_MARKUP;
        o_res.start = 1'b0;
        o_res.ev    = xml_lex_pkg::EV_NONE;
        o_res.err   = 1'b0;
        o_res.epos  = '0;
        o_res.ok    = 1'b0;
        n_state     = r_state;
        n_closing   = r_closing;
        n_pos       = r_pos;
        n_bang      = r_bang;
        n_text      = r_text;
        n_failed    = r_failed;
        bad         = 1'b0;
        errp        = r_pos;

        if (i_cmd == xml_lex_pkg::CMD_END) begin
            if (!r_failed) begin
                if (r_state == xml_lex_pkg::ST_OUT) begin
                    o_res.ok = 1'b1;
                end else if (r_state == xml_lex_pkg::ST_TEXT) begin
                    o_res.ok = 1'b1;
                    if (r_text) begin
                        o_res.ev = xml_lex_pkg::EV_TEXT;
                    end
                end else begin
                    o_res.err = 1'b1;
                    if (r_state == xml_lex_pkg::ST_BANG || r_state == xml_lex_pkg::ST_BANG1) begin
                        o_res.epos = xml_lex_pkg::EPOS_W'(r_bang);
                    end else begin
                        o_res.epos = xml_lex_pkg::EPOS_W'(r_pos);
                    end
                end
            end
            // end mark always starts a fresh text
            n_state   = xml_lex_pkg::ST_OUT;
            n_closing = 1'b0;
            n_pos     = '0;
            n_bang    = '0;
            n_text    = 1'b0;
            n_failed  = 1'b0;
        end else if (!r_failed) begin
            case (r_state)
                xml_lex_pkg::ST_LT: begin
                    if (i_char == xml_lex_pkg::CH_BANG) begin
                        n_bang  = r_pos;
                        n_state = xml_lex_pkg::ST_BANG;
                    end else if (blank) begin
                        n_state = r_state;
                    end else if (i_char == xml_lex_pkg::CH_SLASH) begin
                        n_closing = 1'b1;
                        n_state   = xml_lex_pkg::ST_SLASH;
                    end else if (letter) begin
                        o_res.role  = xml_lex_pkg::ROLE_TAG;
                        o_res.start = 1'b1;
                        n_state     = xml_lex_pkg::ST_NAME;
                    end else begin
                        bad = 1'b1;
                    end
                end
                xml_lex_pkg::ST_BANG: begin
                    if (i_char == xml_lex_pkg::CH_DASH) begin
                        n_state = xml_lex_pkg::ST_BANG1;
                    end else begin
                        bad  = 1'b1;
                        errp = r_bang;
                    end
                end
                xml_lex_pkg::ST_BANG1: begin
                    if (i_char == xml_lex_pkg::CH_DASH) begin
                        n_state = xml_lex_pkg::ST_CMT;
                    end else begin
                        bad  = 1'b1;
                        errp = r_bang;
                    end
                end
                xml_lex_pkg::ST_SLASH: begin
                    if (blank) begin
                        n_state = r_state;
                    end else if (letter) begin
                        o_res.role  = xml_lex_pkg::ROLE_TAG;
                        o_res.start = 1'b1;
                        n_state     = xml_lex_pkg::ST_NAME;
                    end else begin
                        bad = 1'b1;
                    end
                end
                xml_lex_pkg::ST_NAME: begin
                    if (letter) begin
                        o_res.role = xml_lex_pkg::ROLE_TAG;
                    end else if (i_char == xml_lex_pkg::CH_GT) begin
                        o_res.ev = tagdone;
                        n_state  = xml_lex_pkg::ST_OUT;
                    end else if (i_char == xml_lex_pkg::CH_SLASH) begin
                        if (r_closing) begin
                            bad = 1'b1;
                        end else begin
                            n_state = xml_lex_pkg::ST_GT;
                        end
                    end else if (blank) begin
                        n_state = xml_lex_pkg::ST_ATTRWS;
                    end else begin
                        bad = 1'b1;
                    end
                end
                xml_lex_pkg::ST_ATTRWS, xml_lex_pkg::ST_AFTVWS: begin
                    if (blank) begin
                        n_state = r_state;
                    end else if (letter) begin
                        o_res.role  = xml_lex_pkg::ROLE_ANAME;
                        o_res.start = 1'b1;
                        n_state     = xml_lex_pkg::ST_ANAME;
                    end else if (i_char == xml_lex_pkg::CH_GT) begin
                        o_res.ev = tagdone;
                        n_state  = xml_lex_pkg::ST_OUT;
                    end else if (i_char == xml_lex_pkg::CH_SLASH) begin
                        if (r_closing) begin
                            bad = 1'b1;
                        end else begin
                            n_state = xml_lex_pkg::ST_GT;
                        end
                    end else begin
                        bad = 1'b1;
                    end
                end
                xml_lex_pkg::ST_ANAME: begin
                    if (blank) begin
                        n_state = xml_lex_pkg::ST_PREEQ;
                    end else if (letter) begin
                        o_res.role = xml_lex_pkg::ROLE_ANAME;
                    end else if (i_char == xml_lex_pkg::CH_EQ) begin
                        n_state = xml_lex_pkg::ST_EQ;
                    end else begin
                        bad = 1'b1;
                    end
                end
                xml_lex_pkg::ST_PREEQ: begin
                    if (blank) begin
                        n_state = r_state;
                    end else if (i_char == xml_lex_pkg::CH_EQ) begin
                        n_state = xml_lex_pkg::ST_EQ;
                    end else begin
                        bad = 1'b1;
                    end
                end
                xml_lex_pkg::ST_EQ, xml_lex_pkg::ST_PREQ: begin
                    if (blank) begin
                        n_state = xml_lex_pkg::ST_PREQ;
                    end else if (i_char == xml_lex_pkg::CH_QUOTE) begin
                        n_state = xml_lex_pkg::ST_VFIRST;
                    end else begin
                        bad = 1'b1;
                    end
                end
                xml_lex_pkg::ST_VFIRST, xml_lex_pkg::ST_VAL: begin
                    if (i_char == xml_lex_pkg::CH_QUOTE) begin
                        o_res.ev = xml_lex_pkg::EV_VALUE;
                        n_state  = xml_lex_pkg::ST_AFTV;
                    end else begin
                        o_res.role  = xml_lex_pkg::ROLE_AVAL;
                        o_res.start = (r_state == xml_lex_pkg::ST_VFIRST);
                        n_state     = xml_lex_pkg::ST_VAL;
                    end
                end
                xml_lex_pkg::ST_AFTV: begin
                    if (blank) begin
                        n_state = xml_lex_pkg::ST_AFTVWS;
                    end else if (i_char == xml_lex_pkg::CH_SLASH) begin
                        if (r_closing) begin
                            bad = 1'b1;
                        end else begin
                            n_state = xml_lex_pkg::ST_GT;
                        end
                    end else if (i_char == xml_lex_pkg::CH_GT) begin
                        o_res.ev = tagdone;
                        n_state  = xml_lex_pkg::ST_OUT;
                    end else begin
                        bad = 1'b1;
                    end
                end
                xml_lex_pkg::ST_GT: begin
                    if (i_char == xml_lex_pkg::CH_GT) begin
                        o_res.ev = xml_lex_pkg::EV_EMPTY;
                        n_state  = xml_lex_pkg::ST_OUT;
                    end else begin
                        bad = 1'b1;
                    end
                end
                xml_lex_pkg::ST_TEXT: begin
                    if (i_char == xml_lex_pkg::CH_LT) begin
                        if (r_text) begin
                            o_res.ev = xml_lex_pkg::EV_TEXT;
                        end
                        n_closing = 1'b0;
                        n_state   = xml_lex_pkg::ST_LT;
                    end else begin
                        o_res.role = xml_lex_pkg::ROLE_TEXT;
                        if (!blank) begin
                            n_text = 1'b1;
                        end
                    end
                end
                xml_lex_pkg::ST_CMT: begin
                    o_res.role = xml_lex_pkg::ROLE_CMT;
                    if (i_char == xml_lex_pkg::CH_DASH) begin
                        n_state = xml_lex_pkg::ST_CMT1;
                    end
                end
                xml_lex_pkg::ST_CMT1: begin
                    o_res.role = xml_lex_pkg::ROLE_CMT;
                    n_state = (i_char == xml_lex_pkg::CH_DASH) ? xml_lex_pkg::ST_CMT2
                                                                : xml_lex_pkg::ST_CMT;
                end
                xml_lex_pkg::ST_CMT2: begin
                    o_res.role = xml_lex_pkg::ROLE_CMT;
                    if (i_char == xml_lex_pkg::CH_GT) begin
                        n_state = xml_lex_pkg::ST_OUT;
                    end else if (i_char != xml_lex_pkg::CH_DASH) begin
                        n_state = xml_lex_pkg::ST_CMT;
                    end
                end
                default: begin
                    // outside markup
                    if (i_char == xml_lex_pkg::CH_LT) begin
                        n_closing = 1'b0;
                        n_state   = xml_lex_pkg::ST_LT;
                    end else begin
                        o_res.role  = xml_lex_pkg::ROLE_TEXT;
                        o_res.start = 1'b1;
                        n_state     = xml_lex_pkg::ST_TEXT;
                        n_text      = !blank;
                    end
                end
            endcase

            if (bad) begin
                o_res.role  = xml_lex_pkg::ROLE_MARKUP;
                o_res.start = 1'b0;
                o_res.ev    = xml_lex_pkg::EV_NONE;
                o_res.err   = 1'b1;
                o_res.epos  = xml_lex_pkg::EPOS_W'(errp);
                n_failed    = 1'b1;
            end

            // saturate the position
            if (r_pos != {xml_lex_pkg::POS_BITS{1'b1}}) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= xml_lex_pkg::ST_OUT;
            r_closing <= 1'b0;
            r_pos     <= '0;
            r_bang    <= '0;
            r_text    <= 1'b0;
            r_failed  <= 1'b0;
        end else if (i_adv) begin
            r_state   <= n_state;
            r_closing <= n_closing;
            r_pos     <= n_pos;
            r_bang    <= n_bang;
            r_text    <= n_text;
            r_failed  <= n_failed;
        end
    end

endmodule

### hdl/xml_markup_lexer_core.sv
// Top level of the streaming XML markup lexer: input register, lexer step, result register.
`include "xml_markup_lexer_core_defines.svh"

// Streaming XML lexer. Each input word is one text byte (tuser = 0) or an end-of-text
// mark (tuser = 1); each gives exactly one result word with the byte role, token start,
// completion event, error flag and position, and an accept flag on the end mark.
// Throughput is one word per clock while results drain: the lexer state machine takes one
// transition per word between an input register and a result register, so an accepted
// word is held in the input register and then offered from the result register. While a
// result waits downstream, one more word is taken into the input register before the
// input stalls. After a syntax error, bytes give all-zero results until the end mark, which
// also returns the lexer to its reset state.
module xml_markup_lexer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [xml_lex_pkg::CHAR_W-1:0]       s_axis_tdata,  // [7:0] char_code
    input  logic [0:0]                           s_axis_tuser,  // [0] cmd
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [2:0] char_role, [3] token_start, [6:4] event_res, [7] error,
    // [23:8] error_pos, [24] done_ok, [31:25] zero
    output logic [xml_lex_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int RES_W = $bits(xml_lex_pkg::t_result);

    logic                              r_in_valid;
    logic                              r_in_cmd;
    logic [xml_lex_pkg::CHAR_W-1:0]    r_in_char;
    logic                              r_out_valid;
    xml_lex_pkg::t_result              r_out;
    xml_lex_pkg::t_result              step_res;
    logic                              adv;
    logic                              in_take;

    // advance the held word into the result register when it is free or drains now
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    xml_lex_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cmd   (r_in_cmd),
        .i_char  (r_in_char),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd  <= s_axis_tuser[0];
            r_in_char <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(xml_lex_pkg::OUT_DATA_W - RES_W){1'b0}},
                            r_out.ok, r_out.epos, r_out.err, r_out.ev,
                            r_out.start, r_out.role};

    `XML_ASSERT(a_err_clean,
        r_out_valid && r_out.err |-> r_out.role == xml_lex_pkg::ROLE_MARKUP
            && !r_out.start && r_out.ev == xml_lex_pkg::EV_NONE,
        "error result carries role or start or event")
    `XML_ASSERT(a_err_not_ok, r_out_valid |-> !(r_out.err && r_out.ok),
        "error and accept flagged together")
    `XML_ASSERT(a_stall_cause,
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready,
        "input stalled without a full pipeline")
    `XML_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_axis_tvalid && s_axis_tready,
        "pipeline not empty after reset")

endmodule

### test/xml_markup_lexer_core_test.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the XML markup lexer core.
module xml_markup_lexer_core_test;
    import xml_lex_pkg::*;

    localparam int RANDOM_WORDS = 1650;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic       fixed;
        t_result    want;
    } t_script_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CHAR_W-1:0]     s_axis_tdata  = '0;  // [7:0] char_code
    logic [0:0]            s_axis_tuser  = '0;  // [0] cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [2:0] char_role, [3] token_start, [6:4] event_res, [7] error,
    // [23:8] error_pos, [24] done_ok
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // lexer state as the checker tracks it
    logic [STATE_W-1:0]  lx_state;
    logic                lx_closing;
    logic [POS_BITS-1:0] lx_pos;
    logic [POS_BITS-1:0] lx_bang;
    logic                lx_has_text;
    logic                lx_failed;

    t_result expected_results[$];
    int      mismatches = 0;
    int      result_count = 0;
    int      live_words = 0;
    bit      steady = 1'b0;

    always #5 i_clk = ~i_clk;

    initial begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

    xml_markup_lexer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic blank_byte(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // fold upper case onto lower case; no other byte lands in a..z
    function automatic logic letter_byte(input logic [7:0] c);
        logic [7:0] f;
        f = c | 8'h20;
        return (c[7] == 1'b0) && f >= "a" && f <= "z";
    endfunction

    function automatic void lexer_clear();
        lx_state    = ST_OUT;
        lx_closing  = 1'b0;
        lx_pos      = '0;
        lx_bang     = '0;
        lx_has_text = 1'b0;
        lx_failed   = 1'b0;
    endfunction

    function automatic t_result lex_predict(input logic cmd, input logic [7:0] c);
        t_result             r;
        logic [STATE_W-1:0]  s;
        logic [POS_BITS-1:0] p;
        logic                bad;
        logic [2:0]          tag_ev;
        r      = '0;
        s      = lx_state;
        p      = lx_pos;
        bad    = 1'b0;
        tag_ev = lx_closing ? EV_CLOSE : EV_OPEN;
        if (cmd == CMD_END) begin
            if (!lx_failed) begin
                if (s == ST_OUT) begin
                    r.ok = 1'b1;
                end else if (s == ST_TEXT) begin
                    r.ok = 1'b1;
                    if (lx_has_text) r.ev = EV_TEXT;
                end else begin
                    r.err  = 1'b1;
                    r.epos = EPOS_W'((s == ST_BANG || s == ST_BANG1) ? lx_bang : p);
                end
            end
            lexer_clear();
        end else if (!lx_failed) begin
            case (s)
                ST_LT: begin
                    if (c == CH_BANG) begin
                        lx_bang = p;
                        s = ST_BANG;
                    end else if (blank_byte(c)) begin
                    end else if (c == CH_SLASH) begin
                        lx_closing = 1'b1;
                        s = ST_SLASH;
                    end else if (letter_byte(c)) begin
                        r.role = ROLE_TAG; r.start = 1'b1; s = ST_NAME;
                    end else bad = 1'b1;
                end
                ST_BANG, ST_BANG1: begin
                    // a bad opener reports where the bang stood
                    if (c == CH_DASH) s = (s == ST_BANG) ? ST_BANG1 : ST_CMT;
                    else begin
                        bad = 1'b1;
                        p = lx_bang;
                    end
                end
                ST_SLASH: begin
                    if (blank_byte(c)) begin
                    end else if (letter_byte(c)) begin
                        r.role = ROLE_TAG; r.start = 1'b1; s = ST_NAME;
                    end else bad = 1'b1;
                end
                ST_NAME: begin
                    if (letter_byte(c)) r.role = ROLE_TAG;
                    else if (c == CH_GT) begin
                        r.ev = tag_ev; s = ST_OUT;
                    end else if (c == CH_SLASH) begin
                        if (lx_closing) bad = 1'b1;
                        else s = ST_GT;
                    end else if (blank_byte(c)) s = ST_ATTRWS;
                    else bad = 1'b1;
                end
                ST_ATTRWS, ST_AFTVWS: begin
                    if (blank_byte(c)) begin
                    end else if (letter_byte(c)) begin
                        r.role = ROLE_ANAME; r.start = 1'b1; s = ST_ANAME;
                    end else if (c == CH_GT) begin
                        r.ev = tag_ev; s = ST_OUT;
                    end else if (c == CH_SLASH) begin
                        if (lx_closing) bad = 1'b1;
                        else s = ST_GT;
                    end else bad = 1'b1;
                end
                ST_ANAME: begin
                    if (blank_byte(c)) s = ST_PREEQ;
                    else if (letter_byte(c)) r.role = ROLE_ANAME;
                    else if (c == CH_EQ) s = ST_EQ;
                    else bad = 1'b1;
                end
                ST_PREEQ: begin
                    if (blank_byte(c)) begin
                    end else if (c == CH_EQ) s = ST_EQ;
                    else bad = 1'b1;
                end
                ST_EQ, ST_PREQ: begin
                    if (blank_byte(c)) s = ST_PREQ;
                    else if (c == CH_QUOTE) s = ST_VFIRST;
                    else bad = 1'b1;
                end
                ST_VFIRST, ST_VAL: begin
                    if (c == CH_QUOTE) begin
                        r.ev = EV_VALUE; s = ST_AFTV;
                    end else begin
                        r.role  = ROLE_AVAL;
                        r.start = (s == ST_VFIRST);
                        s = ST_VAL;
                    end
                end
                ST_AFTV: begin
                    if (blank_byte(c)) s = ST_AFTVWS;
                    else if (c == CH_SLASH) begin
                        if (lx_closing) bad = 1'b1;
                        else s = ST_GT;
                    end else if (c == CH_GT) begin
                        r.ev = tag_ev; s = ST_OUT;
                    end else bad = 1'b1;
                end
                ST_GT: begin
                    if (c == CH_GT) begin
                        r.ev = EV_EMPTY; s = ST_OUT;
                    end else bad = 1'b1;
                end
                ST_TEXT: begin
                    if (c == CH_LT) begin
                        if (lx_has_text) r.ev = EV_TEXT;
                        lx_closing = 1'b0;
                        s = ST_LT;
                    end else begin
                        r.role = ROLE_TEXT;
                        if (!blank_byte(c)) lx_has_text = 1'b1;
                    end
                end
                ST_CMT: begin
                    r.role = ROLE_CMT;
                    if (c == CH_DASH) s = ST_CMT1;
                end
                ST_CMT1: begin
                    r.role = ROLE_CMT;
                    s = (c == CH_DASH) ? ST_CMT2 : ST_CMT;
                end
                ST_CMT2: begin
                    r.role = ROLE_CMT;
                    if (c == CH_GT) s = ST_OUT;
                    else if (c != CH_DASH) s = ST_CMT;
                end
                default: begin
                    if (c == CH_LT) begin
                        lx_closing = 1'b0;
                        s = ST_LT;
                    end else begin
                        r.role = ROLE_TEXT; r.start = 1'b1; s = ST_TEXT;
                        lx_has_text = !blank_byte(c);
                    end
                end
            endcase
            if (bad) begin
                r = '0;
                r.err  = 1'b1;
                r.epos = EPOS_W'(p);
                lx_failed = 1'b1;
            end
            lx_state = s;
            if (lx_pos != '1) lx_pos = lx_pos + 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: result %0d %s: got %0h, want %0h", $realtime, result_count,
                 what, got, want);
        mismatches++;
    endtask

    // Offer one word, wait for the handshake, then queue what it should produce.
    task automatic drive_word(input logic cmd, input logic [7:0] ch, input logic fixed,
                              input t_result want);
        t_result r;
        if (!steady && $urandom_range(0, 99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_END || !lx_failed) live_words++;
        r = lex_predict(cmd, ch);
        expected_results.push_back(fixed ? want : r);
    endtask

    function automatic logic [7:0] blank_pick();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'(8'h09 + k);
    endfunction

    function automatic logic [7:0] letter_pick();
        logic [7:0] c;
        c = 8'("A" + $urandom_range(0, 25));
        return $urandom_range(0, 1) ? (c | 8'h20) : c;
    endfunction

    task automatic emit_fragment();
        logic [7:0] frag[$];
        logic [7:0] c;
        int         kind;
        kind = $urandom_range(0, 99);
        // after an error, mostly close the document
        if (lx_failed && $urandom_range(0, 9) < 7) kind = 85;
        if (kind < 15) begin
            repeat ($urandom_range(1, 6)) begin
                c = $urandom_range(0, 9) < 3 ? blank_pick() : 8'($urandom_range(0, 255));
                frag.push_back(c == CH_LT ? 8'h20 : c);
            end
        end else if (kind < 55) begin
            frag.push_back(CH_LT);
            if ($urandom_range(0, 9) == 0) frag.push_back(blank_pick());
            repeat ($urandom_range(1, 5)) frag.push_back(letter_pick());
            repeat ($urandom_range(0, 2)) begin
                repeat ($urandom_range(1, 2)) frag.push_back(blank_pick());
                repeat ($urandom_range(1, 4)) frag.push_back(letter_pick());
                if ($urandom_range(0, 3) == 0) frag.push_back(blank_pick());
                frag.push_back(CH_EQ);
                if ($urandom_range(0, 3) == 0) frag.push_back(blank_pick());
                frag.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 4)) begin
                    c = 8'($urandom_range(0, 255));
                    frag.push_back(c == CH_QUOTE ? letter_pick() : c);
                end
                frag.push_back(CH_QUOTE);
            end
            if ($urandom_range(0, 3) == 0) frag.push_back(blank_pick());
            if ($urandom_range(0, 2) == 0) frag.push_back(CH_SLASH);
            frag.push_back(CH_GT);
        end else if (kind < 70) begin
            frag.push_back(CH_LT);
            frag.push_back(CH_SLASH);
            if ($urandom_range(0, 7) == 0) frag.push_back(blank_pick());
            repeat ($urandom_range(1, 5)) frag.push_back(letter_pick());
            if ($urandom_range(0, 3) == 0) frag.push_back(blank_pick());
            frag.push_back(CH_GT);
        end else if (kind < 80) begin
            frag.push_back(CH_LT);
            frag.push_back(CH_BANG);
            frag.push_back(CH_DASH);
            frag.push_back(CH_DASH);
            repeat ($urandom_range(0, 6))
                frag.push_back($urandom_range(0, 9) < 3 ? CH_DASH : 8'($urandom_range(0, 255)));
            frag.push_back(CH_DASH);
            frag.push_back(CH_DASH);
            frag.push_back(CH_GT);
        end else if (kind >= 90) begin
            repeat ($urandom_range(1, 4)) frag.push_back(8'($urandom_range(0, 255)));
        end
        // break a well-formed fragment now and then
        if (frag.size() != 0 && $urandom_range(0, 19) == 0)
            frag[$urandom_range(0, frag.size() - 1)] = 8'($urandom_range(0, 255));
        foreach (frag[i]) drive_word(CMD_BYTE, frag[i], 1'b0, '0);
        if (kind >= 80 && kind < 90) drive_word(CMD_END, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.role  = m_axis_tdata[2:0];
            got.start = m_axis_tdata[3];
            got.ev    = m_axis_tdata[6:4];
            got.err   = m_axis_tdata[7];
            got.epos  = m_axis_tdata[23:8];
            got.ok    = m_axis_tdata[24];
            if (expected_results.size() == 0) begin
                report_mismatch("word with nothing pending", m_axis_tdata, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.role != want.role)
                    report_mismatch("char_role", 32'(got.role), 32'(want.role));
                if (got.start != want.start)
                    report_mismatch("token_start", 32'(got.start), 32'(want.start));
                if (got.ev != want.ev)
                    report_mismatch("event_res", 32'(got.ev), 32'(want.ev));
                if (got.err != want.err)
                    report_mismatch("error", 32'(got.err), 32'(want.err));
                if (got.epos != want.epos)
                    report_mismatch("error_pos", 32'(got.epos), 32'(want.epos));
                if (got.ok != want.ok)
                    report_mismatch("done_ok", 32'(got.ok), 32'(want.ok));
            end
            result_count++;
        end
    end

    initial begin
        t_script_row script[31];
        bit          paused;
        paused = 1'b0;
        lexer_clear();
        script = '{
            '{CMD_END,  8'hFF,    1'b1, '{ROLE_MARKUP, 1'b0, EV_NONE, 1'b0, 16'd0, 1'b1}},
            '{CMD_BYTE, 8'h20,    1'b0, '0},   // blank-only text run
            '{CMD_BYTE, CH_LT,    1'b0, '0},
            '{CMD_BYTE, CH_BANG,  1'b0, '0},
            '{CMD_BYTE, CH_DASH,  1'b0, '0},
            '{CMD_BYTE, CH_DASH,  1'b0, '0},
            '{CMD_BYTE, 8'hFF,    1'b1, '{ROLE_CMT, 1'b0, EV_NONE, 1'b0, 16'd0, 1'b0}},
            '{CMD_BYTE, CH_DASH,  1'b0, '0},
            '{CMD_BYTE, CH_DASH,  1'b0, '0},
            '{CMD_BYTE, CH_GT,    1'b0, '0},
            '{CMD_BYTE, CH_LT,    1'b0, '0},
            '{CMD_BYTE, "A",      1'b0, '0},
            '{CMD_BYTE, 8'h20,    1'b0, '0},
            '{CMD_BYTE, "z",      1'b0, '0},
            '{CMD_BYTE, CH_EQ,    1'b0, '0},
            '{CMD_BYTE, CH_QUOTE, 1'b0, '0},
            '{CMD_BYTE, 8'h00,    1'b0, '0},
            '{CMD_BYTE, CH_QUOTE, 1'b0, '0},
            '{CMD_BYTE, CH_SLASH, 1'b0, '0},
            '{CMD_BYTE, CH_GT,    1'b1, '{ROLE_MARKUP, 1'b0, EV_EMPTY, 1'b0, 16'd0, 1'b0}},
            '{CMD_BYTE, "q",      1'b0, '0},
            '{CMD_END,  8'h00,    1'b1, '{ROLE_MARKUP, 1'b0, EV_TEXT, 1'b0, 16'd0, 1'b1}},
            // slash inside a closing tag
            '{CMD_BYTE, CH_LT,    1'b0, '0},
            '{CMD_BYTE, CH_SLASH, 1'b0, '0},
            '{CMD_BYTE, "b",      1'b0, '0},
            '{CMD_BYTE, CH_SLASH, 1'b1, '{ROLE_MARKUP, 1'b0, EV_NONE, 1'b1, 16'd3, 1'b0}},
            '{CMD_BYTE, 8'h7F,    1'b1, '0},
            '{CMD_END,  8'hAA,    1'b1, '0},
            // opener cut short by the end mark
            '{CMD_BYTE, CH_LT,    1'b0, '0},
            '{CMD_BYTE, CH_BANG,  1'b0, '0},
            '{CMD_END,  8'h55,    1'b1, '{ROLE_MARKUP, 1'b0, EV_NONE, 1'b1, 16'd1, 1'b0}}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (script[i]) drive_word(script[i].cmd, script[i].ch, script[i].fixed,
                                       script[i].want);

        live_words = 0;
        while (live_words < RANDOM_WORDS) begin
            steady = (live_words >= 400 && live_words < 700);
            if (!paused && live_words >= 900) begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
            emit_fragment();
        end
        steady = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
